/* hw/rtl/dpr_pkg.sv */
package dpr_pkg;

   // Size of the packet byte store; packets with more bytes are dropped.
   localparam int MAX_BYTES = 6;
   // Number of byte outputs on the result channel.
   localparam int OUT_BYTES = 6;
   localparam int BYTE_BITS = 8;
   localparam int BYTE_CNT_W = $clog2(MAX_BYTES + 1);
   localparam int STORE_IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam logic [7:0] PREAMBLE_RESET = 8'd10;
   localparam logic [7:0] BIT_CNT_MAX = 8'hFF;

   typedef logic [BYTE_CNT_W-1:0] byte_cnt_type;

   typedef enum logic [2:0] {
      PH_START    = 3'd0,
      PH_PREAMBLE = 3'd1,
      PH_LEAD0    = 3'd2,
      PH_BYTE     = 3'd3,
      PH_TRAILER  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [2:0]                 byte_count;
      logic [OUT_BYTES-1:0][7:0]  bytes;
   } result_type;

endpackage

/* hw/rtl/dpr_core.sv */
module dpr_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                dcc_bit,
   input  logic                host_busy,
   input  logic                csr_write_enable,
   input  logic [7:0]          csr_write_data,
   output logic                emit,
   output dpr_pkg::result_type result
);

   dpr_pkg::phase_type    phase_ff, phase_in;
   logic [7:0]            bit_cnt_ff, bit_cnt_in, bit_cnt_inc;
   dpr_pkg::byte_cnt_type byte_cnt_ff, byte_cnt_in;
   logic [7:0]            shift_ff, shift_in;
   logic [7:0]            preamble_min_ff;
   logic [7:0]            store_ff [dpr_pkg::MAX_BYTES];
   logic                  store_we;
   logic                  emit_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_min_ff <= dpr_pkg::PREAMBLE_RESET;
      end else if (csr_write_enable) begin
         preamble_min_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= dpr_pkg::PH_START;
         bit_cnt_ff  <= '0;
         byte_cnt_ff <= '0;
         shift_ff    <= '0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         bit_cnt_ff  <= bit_cnt_in;
         byte_cnt_ff <= byte_cnt_in;
         shift_ff    <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dpr_pkg::MAX_BYTES; i++) begin
            store_ff[i] <= '0;
         end
      end else if (step_en && store_we) begin
         store_ff[byte_cnt_ff[dpr_pkg::STORE_IDX_W-1:0]] <= shift_in;
      end
   end

   always_comb begin
      // The run counter saturates so that a long idle line of ones never wraps.
      bit_cnt_inc = (bit_cnt_ff == dpr_pkg::BIT_CNT_MAX) ? bit_cnt_ff : bit_cnt_ff + 8'd1;
      phase_in    = phase_ff;
      bit_cnt_in  = bit_cnt_inc;
      byte_cnt_in = byte_cnt_ff;
      shift_in    = shift_ff;
      store_we    = 1'b0;
      emit_raw    = 1'b0;
      case (phase_ff)
         dpr_pkg::PH_PREAMBLE: begin
            if (dcc_bit) begin
               if (bit_cnt_inc >= preamble_min_ff) begin
                  phase_in = dpr_pkg::PH_LEAD0;
               end
            end else begin
               bit_cnt_in = '0;
            end
         end
         dpr_pkg::PH_LEAD0: begin
            if (!dcc_bit) begin
               byte_cnt_in = '0;
               bit_cnt_in  = '0;
               shift_in    = '0;
               phase_in    = dpr_pkg::PH_BYTE;
            end
         end
         dpr_pkg::PH_BYTE: begin
            shift_in = {shift_ff[6:0], dcc_bit};
            if (bit_cnt_inc == 8'(dpr_pkg::BYTE_BITS)) begin
               // A byte that finds the store full drops the whole packet.
               if (byte_cnt_ff >= dpr_pkg::BYTE_CNT_W'(dpr_pkg::MAX_BYTES)) begin
                  phase_in = dpr_pkg::PH_PREAMBLE;
               end else begin
                  store_we    = 1'b1;
                  byte_cnt_in = byte_cnt_ff + dpr_pkg::BYTE_CNT_W'(1);
                  phase_in    = dpr_pkg::PH_TRAILER;
               end
            end
         end
         dpr_pkg::PH_TRAILER: begin
            if (dcc_bit) begin
               // The end bit is also the first one of the next preamble.
               phase_in   = dpr_pkg::PH_PREAMBLE;
               bit_cnt_in = 8'd1;
               emit_raw   = !host_busy;
            end else begin
               bit_cnt_in = '0;
               shift_in   = '0;
               phase_in   = dpr_pkg::PH_BYTE;
            end
         end
         dpr_pkg::PH_START: begin
            phase_in = dpr_pkg::PH_PREAMBLE;
         end
         default: begin
            phase_in = dpr_pkg::PH_PREAMBLE;
         end
      endcase
   end

   assign emit              = step_en && emit_raw;
   assign result.byte_count = 3'(byte_cnt_ff);

   for (genvar g = 0; g < dpr_pkg::OUT_BYTES; g++) begin : g_out
      if (g < dpr_pkg::MAX_BYTES) begin : g_used
         assign result.bytes[g] = store_ff[g];
      end else begin : g_unused
         assign result.bytes[g] = '0;
      end
   end

   a_byte_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      byte_cnt_ff <= dpr_pkg::BYTE_CNT_W'(dpr_pkg::MAX_BYTES))
      else $error("byte count beyond store size");

   a_bit_idx_in_byte: assert property (@(posedge clock) disable iff (reset)
      phase_ff == dpr_pkg::PH_BYTE |-> bit_cnt_ff < 8'(dpr_pkg::BYTE_BITS))
      else $error("bit index overran a byte");

   a_end_bit_counts: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == dpr_pkg::PH_TRAILER && dcc_bit
      |=> phase_ff == dpr_pkg::PH_PREAMBLE && bit_cnt_ff == 8'd1)
      else $error("end bit not counted towards the next preamble");

endmodule

/* hw/rtl/dpr_out_reg.sv */
module dpr_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  dpr_pkg::result_type result_in,
   input  logic                rsp_ready,
   output logic                space,
   output logic                rsp_valid,
   output dpr_pkg::result_type result
);

   logic                valid_ff, valid_in;
   dpr_pkg::result_type result_ff;

   assign space    = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign result    = result_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!valid_ff || rsp_ready))
      else $error("result register overwritten before it was taken");

endmodule

/* hw/rtl/dcc_packet_bit_receiver.sv */
// DCC packet receiver: each request carries one decoded track bit and the
// host busy flag. The block takes one request per clock cycle for as long as
// its single result register is empty or is being emptied in the same cycle;
// a finished packet is loaded into that register from the request carrying
// its end bit and shows on the rsp_ channel in the cycle after, unless the
// host busy flag of that request is set, which drops it. The user must write
// the preamble length via csr_write_enable and csr_write_data only while no
// request is in flight (not enforced by the block); it resets to 10 ones.
module dcc_packet_bit_receiver (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_dcc_bit,
   input  logic       req_host_busy,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_byte_count,
   output logic [7:0] rsp_byte0,
   output logic [7:0] rsp_byte1,
   output logic [7:0] rsp_byte2,
   output logic [7:0] rsp_byte3,
   output logic [7:0] rsp_byte4,
   output logic [7:0] rsp_byte5,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic                step_en;
   logic                emit;
   logic                space;
   dpr_pkg::result_type core_result;
   dpr_pkg::result_type rsp_result;

   assign req_ready = space;
   assign step_en   = req_valid && space;

   dpr_core u_core (
      .clock            (clock),
      .reset            (reset),
      .step_en          (step_en),
      .dcc_bit          (req_dcc_bit),
      .host_busy        (req_host_busy),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .emit             (emit),
      .result           (core_result)
   );

   dpr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .result_in (core_result),
      .rsp_ready (rsp_ready),
      .space     (space),
      .rsp_valid (rsp_valid),
      .result    (rsp_result)
   );

   assign rsp_byte_count = rsp_result.byte_count;
   assign rsp_byte0      = rsp_result.bytes[0];
   assign rsp_byte1      = rsp_result.bytes[1];
   assign rsp_byte2      = rsp_result.bytes[2];
   assign rsp_byte3      = rsp_result.bytes[3];
   assign rsp_byte4      = rsp_result.bytes[4];
   assign rsp_byte5      = rsp_result.bytes[5];

endmodule
